### hdl/crsp_pkg.sv
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared types and constants of the CSR row scaling preconditioner.
// ----------------------------------------------------------------------------
package crsp_pkg;

	localparam int ACC_W   = 48;
	localparam int NUM_W   = ACC_W + 1;
	localparam int STEPS   = NUM_W;
	localparam int CNT_W   = 6;
	localparam int COL_W   = 16;
	localparam int VAL_W   = 32;
	localparam int THR_W   = 16;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int DATA_W  = COL_W + VAL_W;

	localparam logic [MODE_W-1:0] MODE_DIAG = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ABS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_DIAG = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SMALL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd3;

	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             diag;
	} row_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [ACC_W-1:0] denom;
	} div_req_t;

endpackage

### hdl/crsp_accum.sv
// ----------------------------------------------------------------------------
// crsp_accum
// Row accumulator and row counter; folds one entry per cycle by mode.
// ----------------------------------------------------------------------------
module crsp_accum #(
	parameter int CW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fold,
	input  logic                        close,
	input  logic [crsp_pkg::MODE_W-1:0] mode,
	input  logic [crsp_pkg::COL_W-1:0]  column,
	input  logic [crsp_pkg::VAL_W-1:0]  entry_value,
	input  logic [CW-1:0]               row_last,
	output crsp_pkg::row_t              row,
	output logic [CW-1:0]               row_cnt
);
	import crsp_pkg::*;

	localparam int CMPW = (CW > COL_W) ? CW : COL_W;

	logic [ACC_W-1:0] acc_q;
	logic             diag_q;
	logic             first_q;
	logic [CW-1:0]    row_q;
	logic [ACC_W-1:0] v48;
	logic [VAL_W-1:0] mag32;
	logic [ACC_W:0]   sum;
	logic             col_hit;
	logic             greater;

	assign v48     = {{(ACC_W-VAL_W){entry_value[VAL_W-1]}}, entry_value};
	assign mag32   = entry_value[VAL_W-1] ? (~entry_value + 1'b1) : entry_value;
	assign sum     = {1'b0, acc_q} + {{(ACC_W+1-VAL_W){1'b0}}, mag32};
	assign col_hit = (CMPW'(column) == CMPW'(row_q));
	assign greater = ($signed(v48) > $signed(acc_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			diag_q  <= 1'b0;
			first_q <= 1'b1;
			row_q   <= '0;
		end else if (close) begin
			acc_q   <= '0;
			diag_q  <= 1'b0;
			first_q <= 1'b1;
			row_q   <= (row_q == row_last) ? '0 : row_q + 1'b1;
		end else if (fold) begin
			case (mode)
				MODE_DIAG: begin
					if (!diag_q && col_hit) begin
						acc_q  <= v48;
						diag_q <= 1'b1;
					end
				end
				MODE_ABS: begin
					acc_q <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
				end
				default: begin
					if (first_q || greater)
						acc_q <= v48;
				end
			endcase
			if (col_hit && mode != MODE_DIAG)
				diag_q <= 1'b1;
			first_q <= 1'b0;
		end
	end

	assign row.acc  = acc_q;
	assign row.diag = diag_q;
	assign row_cnt  = row_q;

endmodule

### hdl/crsp_div.sv
// ----------------------------------------------------------------------------
// crsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crsp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crsp_pkg::div_req_t         req,
	output logic                       busy,
	output logic [crsp_pkg::NUM_W-1:0] quot
);
	import crsp_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] n_q;
	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] d_q;
	logic [NUM_W:0]   diff;
	logic             take;

	assign diff = {1'b0, rem_q, n_q[NUM_W-1]} - {2'b00, d_q};
	assign take = !diff[NUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.numer;
			rem_q <= '0;
			d_q   <= req.denom;
		end else if (busy_q) begin
			rem_q <= take ? diff[ACC_W-1:0] : {rem_q[ACC_W-2:0], n_q[NUM_W-1]};
			n_q   <= {n_q[NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = n_q;

endmodule

### hdl/csr_row_scaling_preconditioner.sv
// ----------------------------------------------------------------------------
// csr_row_scaling_preconditioner
// Jacobi-style row scaling over a CSR entry stream: fold entries per row,
// then report a rounded, saturated fixed-point reciprocal and a status.
// ----------------------------------------------------------------------------
// Sequence: an entry that does not close its row is taken in the idle state.
// A closing request passes the accept, evaluate, divide and finish states,
// skipping the divide state when status is not ok; the divide state gathers
// the 49 quotient bits and then waits to see the divider idle, and the finish state waits for a free output register.
// Throughput is set by the divider: one reciprocal at a time.
// Reset clears the row counter and accumulator, mode 0, threshold 1.
module csr_row_scaling_preconditioner #(
	parameter int MAX_ROWS  = 65536,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [crsp_pkg::THR_W-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [crsp_pkg::DATA_W-1:0] s_tdata,   // column, entry_value
	input  logic                        s_tlast,   // row_end
	input  logic                        s_tuser,   // empty_row
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [crsp_pkg::DATA_W-1:0] m_tdata,   // row_index, scale_factor
	output logic [crsp_pkg::STAT_W-1:0] m_tuser    // status
);
	import crsp_pkg::*;

	localparam int CW = $clog2(MAX_ROWS);
	localparam int RW = (CW > COL_W) ? CW : COL_W;
	localparam logic [CW-1:0]    ROW_LAST = CW'(MAX_ROWS - 1);
	localparam logic [NUM_W-1:0] ONE2     = NUM_W'(1) << (2 * FRAC_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [MODE_W-1:0] mode_q;
	logic [THR_W-1:0]  thr_q;
	logic              take_in;
	logic              fold;
	logic              close;
	row_t              row;
	logic [CW-1:0]     row_cnt;
	div_req_t          dreq;
	logic              div_busy;
	logic [NUM_W-1:0]  quot;
	logic              neg;
	logic [ACC_W-1:0]  mag;
	logic [STAT_W-1:0] stat;
	logic              out_free;
	logic              neg_q;
	logic [STAT_W-1:0] stat_q;
	logic [COL_W-1:0]  ridx_q;
	logic [VAL_W-1:0]  scale;
	logic              out_vld_q;
	logic [DATA_W-1:0] out_data_q;
	logic [STAT_W-1:0] out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DIAG;
			thr_q  <= THR_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[MODE_W-1:0];
				REG_THRESH: thr_q  <= cfg_data;
				default:    mode_q <= mode_q;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign take_in  = s_tvalid && s_tready;
	assign fold     = take_in && !s_tuser;
	assign close    = (state_q == ST_EVAL);

	crsp_accum #(.CW(CW)) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.fold        (fold),
		.close       (close),
		.mode        (mode_q),
		.column      (s_tdata[COL_W-1:0]),
		.entry_value (s_tdata[DATA_W-1:COL_W]),
		.row_last    (ROW_LAST),
		.row         (row),
		.row_cnt     (row_cnt)
	);

	always_comb begin
		if (mode_q == MODE_ABS) begin
			neg = 1'b0;
			mag = row.acc;
		end else begin
			neg = row.acc[ACC_W-1];
			mag = neg ? (~row.acc + 1'b1) : row.acc;
		end
		if (mode_q == MODE_DIAG) begin
			if (!row.diag)
				stat = STAT_NO_DIAG;
			else if (mag == '0)
				stat = STAT_ZERO;
			else
				stat = STAT_OK;
		end else begin
			if (mag < {{(ACC_W-THR_W){1'b0}}, thr_q})
				stat = STAT_SMALL;
			else if (mag == '0)
				stat = STAT_ZERO;
			else
				stat = STAT_OK;
		end
	end

	assign dreq.start = close && (stat == STAT_OK);
	assign dreq.numer = ONE2 + {2'b00, mag[ACC_W-1:1]};
	assign dreq.denom = mag;

	crsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (close) begin
			neg_q  <= neg;
			stat_q <= stat;
			ridx_q <= COL_W'(RW'(row_cnt));
		end
	end

	always_comb begin
		if (stat_q != STAT_OK)
			scale = '0;
		else if (!neg_q)
			scale = (quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[VAL_W-1:0];
		else
			scale = (quot >= NUM_W'(32'h8000_0000)) ? 32'h8000_0000 :
				(~quot[VAL_W-1:0] + 1'b1);
	end

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take_in && (s_tuser || s_tlast))
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= (stat == STAT_OK) ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (!div_busy)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE && out_free)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {scale, ridx_q};
			out_user_q <= stat_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider busy outside divide state");

	a_close_clears_row: assert property (@(posedge clk) disable iff (!arst_n)
		close |=> (row.acc == '0 && !row.diag))
		else $error("row state not cleared after close");

	a_bad_status_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[DATA_W-1:COL_W] == '0))
		else $error("nonzero scale with failing status");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside finish state");

endmodule

### bench/csr_row_scaling_preconditioner_check.sv
// ----------------------------------------------------------------------------
// csr_row_scaling_preconditioner_check
// Watches the register port and both stream channels of the row scaling
// block. Every accepted request is folded into a private copy of the row
// state, and each row close queues the expected row index, reciprocal and
// status. Every accepted result is checked field by field against the
// oldest queued row.
// ----------------------------------------------------------------------------
module csr_row_scaling_preconditioner_check
	import crsp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [THR_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // column, entry_value
	input  logic              s_tlast,   // row_end
	input  logic              s_tuser,   // empty_row
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,   // row_index, scale_factor
	input  logic [STAT_W-1:0] m_tuser,   // status
	output int                errors,
	output int                pending,
	output int                rows_checked
);

	typedef struct packed {
		logic [COL_W-1:0]  row;
		logic [VAL_W-1:0]  scale;
		logic [STAT_W-1:0] status;
	} row_scale_t;

	row_scale_t        row_scale_q[$];
	row_scale_t        want;
	logic [COL_W-1:0]  row_count;
	logic [ACC_W-1:0]  row_acc;
	logic              diag_seen;
	logic              row_open;
	logic [MODE_W-1:0] mode;
	logic [THR_W-1:0]  thresh;

	function automatic logic [VAL_W-1:0] reciprocal(input logic neg, input logic [ACC_W-1:0] mag);
		logic [63:0] q;
		q = ((64'd1 << (2 * FRAC_BITS)) + {16'd0, mag} / 2) / {16'd0, mag};
		if (!neg)
			return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		if (q >= 64'h8000_0000)
			return 32'h8000_0000;
		return -q[31:0];
	endfunction

	function void fold_request(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
			input logic last, input logic empty);
		logic [ACC_W-1:0]  wide;
		logic [ACC_W-1:0]  part;
		logic [ACC_W:0]    sum;
		logic [ACC_W-1:0]  mag;
		logic              neg;
		logic [STAT_W-1:0] status;
		row_scale_t        res;
		wide = {{(ACC_W - VAL_W){val[VAL_W-1]}}, val};
		if (!empty) begin
			if (mode == MODE_DIAG) begin
				if (!diag_seen && col == row_count) begin
					row_acc = wide;
					diag_seen = 1'b1;
				end
			end else if (mode == MODE_ABS) begin
				part = wide[ACC_W-1] ? -wide : wide;
				sum = {1'b0, row_acc} + {1'b0, part};
				row_acc = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
			end else begin
				if (row_open || $signed(wide) > $signed(row_acc))
					row_acc = wide;
			end
			if (col == row_count && mode != MODE_DIAG)
				diag_seen = 1'b1;
			row_open = 1'b0;
			if (!last)
				return;
		end
		if (mode == MODE_ABS) begin
			neg = 1'b0;
			mag = row_acc;
		end else begin
			neg = row_acc[ACC_W-1];
			mag = neg ? -row_acc : row_acc;
		end
		if (mode == MODE_DIAG)
			status = !diag_seen ? STAT_NO_DIAG : (mag == 0) ? STAT_ZERO : STAT_OK;
		else
			status = (mag < {32'd0, thresh}) ? STAT_SMALL : (mag == 0) ? STAT_ZERO : STAT_OK;
		res.row = row_count;
		res.scale = (status == STAT_OK) ? reciprocal(neg, mag) : '0;
		res.status = status;
		row_scale_q.push_back(res);
		row_count = row_count + 1'b1;
		row_acc = '0;
		diag_seen = 1'b0;
		row_open = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_scale_q.delete();
			row_count = '0;
			row_acc = '0;
			diag_seen = 1'b0;
			row_open = 1'b1;
			mode = MODE_DIAG;
			thresh = 16'd1;
			errors = 0;
			rows_checked = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MODE)
					mode = cfg_data[MODE_W-1:0];
				else
					thresh = cfg_data;
			end
			if (s_tvalid && s_tready)
				fold_request(s_tdata[COL_W-1:0], s_tdata[COL_W +: VAL_W], s_tlast, s_tuser);
			if (m_tvalid && m_tready) begin
				if (row_scale_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result row %0d scale %h status %0d", $time,
						m_tdata[COL_W-1:0], m_tdata[COL_W +: VAL_W], m_tuser);
				end else begin
					want = row_scale_q.pop_front();
					rows_checked++;
					if (m_tdata[COL_W-1:0] !== want.row) begin
						errors++;
						$display("%0t: row_index mismatch: expected %0d, actual %0d", $time,
							want.row, m_tdata[COL_W-1:0]);
					end
					if (m_tdata[COL_W +: VAL_W] !== want.scale) begin
						errors++;
						$display("%0t: scale_factor mismatch on row %0d: expected %h, actual %h",
							$time, want.row, want.scale, m_tdata[COL_W +: VAL_W]);
					end
					if (m_tuser !== want.status) begin
						errors++;
						$display("%0t: status mismatch on row %0d: expected %0d, actual %0d",
							$time, want.row, want.status, m_tuser);
					end
				end
			end
			pending = row_scale_q.size();
		end
	end

endmodule

### bench/csr_row_scaling_preconditioner_test.sv
// ----------------------------------------------------------------------------
// csr_row_scaling_preconditioner_test
// Drives CSR entry streams into the row scaling block: a directed pass over
// value extremes, every mode, empty rows, saturation and a mid-row mode
// change, then random rows under changing settings and handshake pressure.
// A checker beside the block predicts and compares every row result.
// ----------------------------------------------------------------------------
module csr_row_scaling_preconditioner_test;
	import crsp_pkg::*;

	localparam int TOTAL_REQUESTS = 1450;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int HOLD_CYCLES    = 600;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = REG_MODE;
	logic [THR_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata   = '0;
	logic              s_tlast   = 1'b0;
	logic              s_tuser   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;

	int                fail_count;
	int                pending;
	int                rows_checked;
	int                requests   = 0;
	int                rows_sent  = 0;
	int                gap_pct    = 0;
	int                stall_pct  = 0;
	int                cycle_count = 0;
	int                hold_left  = 0;
	logic              hold_arm   = 1'b0;
	logic              hold_done  = 1'b0;
	logic [THR_W-1:0]  cur_thresh = 16'd1;
	int                phase;
	int                target;
	int                pick;
	logic [MODE_W-1:0] mode_cycle [3] = '{MODE_DIAG, MODE_ABS, MODE_MAX};

	csr_row_scaling_preconditioner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	csr_row_scaling_preconditioner_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (fail_count),
		.pending     (pending),
		.rows_checked(rows_checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d rows outstanding", cycle_count, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [COL_W-1:0] cur_row();
		return rows_sent[COL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(11))
			0: v = '0;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'h8000_0000;
			3: v = $urandom_range(3, 1);
			4: v = $urandom_range(cur_thresh + 2);
			5: v = 32'h0001_0000 << $urandom_range(12);
			6, 7: v = $urandom_range(32'h00FF_FFFF);
			default: v = $urandom();
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	task automatic send(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
			input logic last, input logic empty);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {val, col};
		s_tlast <= last;
		s_tuser <= empty;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests++;
		if (last || empty)
			rows_sent++;
	endtask

	// close a broken row with an empty-row marker instead of an end mark
	task automatic send_row(input int len, input logic broken);
		logic [COL_W-1:0] col;
		for (int i = 0; i < len; i++) begin
			col = ($urandom_range(2) == 0) ? cur_row() : COL_W'($urandom());
			send(col, pick_value(), (i == len - 1) && !broken, 1'b0);
		end
		if (broken)
			send(COL_W'($urandom()), $urandom(), 1'($urandom_range(1)), 1'b1);
	endtask

	task automatic set_reg(input logic idx, input logic [THR_W-1:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESH)
			cur_thresh = val;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: diagonal mode, threshold 1
		send(16'd5, 32'd7, 1'b0, 1'b0);
		send(cur_row(), 32'h0001_0000, 1'b0, 1'b0);
		send(cur_row(), 32'h0002_0000, 1'b1, 1'b0);
		send(16'hFFFF, 32'h1234_5678, 1'b1, 1'b1);
		send(cur_row(), 32'h0000_0000, 1'b1, 1'b0);
		send(cur_row(), 32'h0000_0001, 1'b1, 1'b0);
		send(cur_row(), 32'hFFFF_FFFF, 1'b1, 1'b0);
		send(16'hFFFF, 32'h8000_0000, 1'b1, 1'b0);
		send(cur_row(), 32'h8000_0000, 1'b1, 1'b0);
		send(cur_row(), 32'h7FFF_FFFF, 1'b1, 1'b0);

		// switch mode in the middle of a row
		send(cur_row(), 32'h0003_0000, 1'b0, 1'b0);
		set_reg(REG_MODE, THR_W'(MODE_ABS));
		send(16'd0, 32'hFFFF_0000, 1'b1, 1'b0);

		set_reg(REG_THRESH, 16'hFFFF);
		send(16'd0, 32'h0000_7FFF, 1'b0, 1'b0);
		send(16'd1, 32'hFFFF_8001, 1'b1, 1'b0);
		send(16'd1, 32'h8000_0000, 1'b0, 1'b0);
		send(16'd2, 32'h8000_0000, 1'b1, 1'b0);

		set_reg(REG_MODE, THR_W'(MODE_MAX));
		set_reg(REG_THRESH, 16'd0);
		send(16'd0, -32'sd5, 1'b0, 1'b0);
		send(16'd1, -32'sd3, 1'b1, 1'b0);
		send(16'd3, 32'h0000_0000, 1'b1, 1'b0);
		send(16'd0, 32'h0000_0000, 1'b0, 1'b1);

		set_reg(REG_MODE, THR_W'(MODE_SPARE));
		send(16'd0, 32'hFFFF_0000, 1'b0, 1'b0);
		send(16'd1, 32'hFFFE_0000, 1'b1, 1'b0);

		for (phase = 0; requests < TOTAL_REQUESTS; phase++) begin
			set_reg(REG_MODE, THR_W'(mode_cycle[phase % 3]));
			case (phase % 4)
				0: set_reg(REG_THRESH, 16'd1);
				1: set_reg(REG_THRESH, 16'd0);
				2: set_reg(REG_THRESH, 16'hFFFF);
				default: set_reg(REG_THRESH, THR_W'($urandom_range(4096)));
			endcase
			case ((phase / 3) % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 83; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 83; end
				default: begin gap_pct = 7; stall_pct = 7; end
			endcase
			if (phase == 5) begin
				// hold the output while single-entry rows keep arriving
				gap_pct = 0;
				hold_arm = 1'b1;
				repeat (40) send_row(1, 1'b0);
				hold_arm = 1'b0;
			end
			target = requests + 110;
			while (requests < target && requests < TOTAL_REQUESTS) begin
				pick = $urandom_range(99);
				if (pick < 8)
					send(COL_W'($urandom()), $urandom(), 1'($urandom_range(1)), 1'b1);
				else if (pick < 14)
					send_row($urandom_range(3, 1), 1'b1);
				else if (pick < 95)
					send_row($urandom_range(4, 1), 1'b0);
				else
					send_row($urandom_range(16, 5), 1'b0);
			end
		end

		s_tvalid <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d requests closing %0d rows over %0d setting phases; %0d rows checked",
			requests, rows_sent, phase, rows_checked);
		$display("Modes diagonal, abs sum, max and spare; thresholds 0, 1, 65535; one long hold");
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
